FILE: hdl/kvt_pkg.sv
// ----------------------------------------------------------------------------
// kvt_pkg: shared types and constants of the keyed vote table
// Request and response beats, function and status codes, the cell handoff.
// ----------------------------------------------------------------------------
package kvt_pkg;

   localparam logic [1:0] FN_UPDATE     = 2'd0;
   localparam logic [1:0] FN_FORGET     = 2'd1;
   localparam logic [1:0] FN_PREDICT    = 2'd2;
   localparam logic [1:0] FN_QUARANTINE = 2'd3;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_ARG     = 3'd1;
   localparam logic [2:0] ST_AUTH    = 3'd2;
   localparam logic [2:0] ST_FULL    = 3'd3;
   localparam logic [2:0] ST_REVOKED = 3'd4;
   localparam logic [2:0] ST_ABSTAIN = 3'd5;

   // configuration register indexes
   localparam logic CSR_MIN_VOTES  = 1'b0;
   localparam logic CSR_MIN_MARGIN = 1'b1;

   localparam logic [15:0] VOTE_MAX = 16'hFFFF;
   localparam logic [6:0]  PCT_SCALE = 7'd100;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] feature_key;
      logic [7:0]  style_class;
      logic [7:0]  sample_confidence;
      logic [7:0]  consent_flag;
      logic [7:0]  local_flag;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  best_class;
      logic [15:0] vote_sum;
      logic [7:0]  vote_lead;
      logic [7:0]  certainty;
      logic [31:0] entry_version;
      logic [4:0]  active_count;
      logic [31:0] accepted_count;
      logic [31:0] rejected_count;
      logic [31:0] revoked_count;
      logic [31:0] epoch;
   } rsp_type;

   // Command broadcast from the controller to every cell in the same cycle.
   typedef struct packed {
      logic        alloc;      // the selected cell takes the key
      logic        set_ver;    // the selected cell takes version
      logic        set_active;
      logic        clr_active;
      logic        set_tomb;
      logic        quarantine; // all cells drop active
      logic        vote;       // selected cell bumps one class
      logic        shift;      // selected cell rotates its votes one place
      logic [31:0] key;
      logic [31:0] version;
   } cell_cmd_type;

endpackage

FILE: hdl/kvt_cell.sv
// ----------------------------------------------------------------------------
// kvt_cell: one table entry
// Holds key, flags, version and a rotating ring of class counters; compares
// its key against the broadcast and reports its hit to the priority encoder.
// ----------------------------------------------------------------------------
module kvt_cell #(
   parameter int CLASS_COUNT = 4,
   parameter int CW = 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    sel,
   input  logic                    used,
   input  logic [CW-1:0]           vote_class,
   input  kvt_pkg::cell_cmd_type   cmd,
   output logic                    hit,
   output logic                    active,
   output logic                    tomb,
   output logic [31:0]             version,
   output logic [15:0]             head_vote
);

   logic [31:0] key_ff;
   logic [31:0] ver_ff;
   logic        act_ff, act_in;
   logic        tomb_ff, tomb_in;
   logic [15:0] votes_ff [CLASS_COUNT];

   // compare this entry's key
   assign hit       = used && (key_ff == cmd.key);
   assign active    = act_ff;
   assign tomb      = tomb_ff;
   assign version   = ver_ff;
   assign head_vote = votes_ff[0];

   // flag next state
   always_comb begin
      act_in  = act_ff;
      tomb_in = tomb_ff;
      if (cmd.quarantine) begin
         act_in = 1'b0;
      end
      if (sel && cmd.alloc) begin
         act_in  = 1'b0;
         tomb_in = 1'b0;
      end
      if (sel && cmd.set_active) begin
         act_in = 1'b1;
      end
      if (sel && cmd.clr_active) begin
         act_in = 1'b0;
      end
      if (sel && cmd.set_tomb) begin
         tomb_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff  <= 1'b0;
         tomb_ff <= 1'b0;
      end else begin
         act_ff  <= act_in;
         tomb_ff <= tomb_in;
      end
   end

   // payload: key, version and counter ring
   always_ff @(posedge clock) begin
      if (sel && cmd.alloc) begin
         // a fresh entry starts from zero counters, plus the vote that made it
         key_ff <= cmd.key;
         ver_ff <= cmd.set_ver ? cmd.version : '0;
         for (int c = 0; c < CLASS_COUNT; c++) begin
            votes_ff[c] <= (cmd.vote && CW'(c) == vote_class) ? 16'd1 : 16'd0;
         end
      end else begin
         if (sel && cmd.set_ver) begin
            ver_ff <= cmd.version;
         end
         if (sel && cmd.shift) begin
            for (int c = 0; c < CLASS_COUNT - 1; c++) begin
               votes_ff[c] <= votes_ff[c+1];
            end
            votes_ff[CLASS_COUNT-1] <= votes_ff[0];
         end else if (sel && cmd.vote) begin
            if (votes_ff[vote_class] != kvt_pkg::VOTE_MAX) begin
               votes_ff[vote_class] <= votes_ff[vote_class] + 16'd1;
            end
         end
      end
   end

endmodule

FILE: hdl/kvt_divider.sv
// ----------------------------------------------------------------------------
// kvt_divider: restoring divider, one quotient bit per cycle
// Computes (best * 100) / total for the confidence percentage.
// ----------------------------------------------------------------------------
module kvt_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [22:0] dividend,
   input  logic [15:0] divisor,
   output logic        done,
   output logic [22:0] quotient
);

   logic [22:0] quo_ff, quo_in;
   logic [16:0] rem_ff, rem_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [16:0] trial;

   assign done     = done_ff;
   assign quotient = quo_ff;

   // shift one dividend bit in, subtract if it fits
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff[15:0], quo_ff[22]};
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         cnt_in = 5'd23;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = trial - {1'b0, divisor};
            quo_in = {quo_ff[21:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[21:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

endmodule

FILE: hdl/keyed_vote_table.sv
// ----------------------------------------------------------------------------
// keyed_vote_table: keyed table of per-class saturating vote counters
// Row of entry cells with a sequencer, class scan and percentage divider.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  req_    | in        | start / busy        | req_data  (kvt_pkg::req_type)
//  rsp_    | out       | rsp_valid strobe    | rsp_data  (kvt_pkg::rsp_type)
//  csr_    | in        | csr_we, csr_index   | csr_wdata (16 bits)
//
// Update, forget, quarantine and a failed-lookup predict pass lookup, execute
// and done on the way to the result strobe; a predict that abstains on its
// thresholds or sees a zero total also passes the scan and divide states, and
// one that forms a percentage also runs the divider. The scan rotates the
// selected cell's counter ring one place a cycle; the divider retires one
// quotient bit a cycle (23 bits). Reset is synchronous and clears control
// state and status counts. One item at a time: busy is high until the result.
// ----------------------------------------------------------------------------
module keyed_vote_table #(
   parameter int MAX_ENTRIES = 16,
   parameter int CLASS_COUNT = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  kvt_pkg::req_type    req_data,
   output logic                rsp_valid,
   output kvt_pkg::rsp_type    rsp_data,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [15:0]         csr_wdata
);

   localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int UW = $clog2(MAX_ENTRIES + 1);
   localparam int CW = $clog2(CLASS_COUNT);
   localparam int SW = $clog2(CLASS_COUNT + 1);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_LOOK  = 6'b000010,
      S_EXEC  = 6'b000100,
      S_SCAN  = 6'b001000,
      S_DIV   = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type    state_ff, state_in;
   kvt_pkg::req_type req_ff;
   logic [15:0]  min_votes_ff;
   logic [7:0]   min_margin_ff;
   logic [UW-1:0] used_ff, used_in;
   logic [31:0]  ver_ff, ver_in;
   logic [31:0]  acc_ff, acc_in, rej_ff, rej_in, rev_ff, rev_in, epoch_ff, epoch_in;
   logic [EW-1:0] sel_ff, sel_in;
   logic         found_ff, found_in;
   logic [2:0]   status_ff, status_in;
   logic [SW-1:0] scan_ff, scan_in;
   logic [15:0]  best_ff, best_in, second_ff, second_in, total_ff, total_in;
   logic [7:0]   bi_ff, bi_in;
   logic [7:0]   pct_ff, pct_in;
   logic [31:0]  pver_ff, pver_in;
   logic         pred_ff, pred_in;
   logic         rsp_valid_ff, rsp_valid_in;

   kvt_pkg::cell_cmd_type cmd;
   logic [MAX_ENTRIES-1:0] hit_vec, act_vec, tomb_vec;
   logic [31:0]  ver_vec  [MAX_ENTRIES];
   logic [15:0]  head_vec [MAX_ENTRIES];
   logic [EW-1:0] hit_idx;
   logic         any_hit;
   logic [UW-1:0] act_cnt;
   logic         div_start, div_done;
   logic [22:0]  div_q;
   logic [15:0]  v;
   logic [7:0]   margin;
   logic         arg_bad;

   // row of entry cells
   for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      kvt_cell #(.CLASS_COUNT(CLASS_COUNT), .CW(CW)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .sel        (sel_ff == EW'(g)),
         .used       (used_ff > UW'(g)),
         .vote_class (req_ff.style_class[CW-1:0]),
         .cmd        (cmd),
         .hit        (hit_vec[g]),
         .active     (act_vec[g]),
         .tomb       (tomb_vec[g]),
         .version    (ver_vec[g]),
         .head_vote  (head_vec[g])
      );
   end

   kvt_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({7'd0, best_ff} * 23'(kvt_pkg::PCT_SCALE)),
      .divisor  (total_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // priority encode the key match, count live entries
   always_comb begin
      hit_idx = '0;
      any_hit = 1'b0;
      act_cnt = '0;
      for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            hit_idx = EW'(i);
            any_hit = 1'b1;
         end
      end
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         act_cnt = act_cnt + UW'(act_vec[i] && !tomb_vec[i]);
      end
   end

   assign arg_bad = (req_ff.feature_key == '0);
   assign v       = head_vec[sel_ff];
   assign margin  = best_ff[7:0] - second_ff[7:0];

   // sequencer
   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      ver_in       = ver_ff;
      acc_in       = acc_ff;
      rej_in       = rej_ff;
      rev_in       = rev_ff;
      epoch_in     = epoch_ff;
      sel_in       = sel_ff;
      found_in     = found_ff;
      status_in    = status_ff;
      scan_in      = scan_ff;
      best_in      = best_ff;
      second_in    = second_ff;
      total_in     = total_ff;
      bi_in        = bi_ff;
      pct_in       = pct_ff;
      pver_in      = pver_ff;
      pred_in      = pred_ff;
      rsp_valid_in = 1'b0;
      div_start    = 1'b0;
      cmd          = '0;
      cmd.key      = req_ff.feature_key;
      cmd.version  = ver_ff + 32'd1;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            found_in = any_hit;
            sel_in   = any_hit ? hit_idx : used_ff[EW-1:0];
            state_in = S_EXEC;
         end
         S_EXEC: begin
            status_in = kvt_pkg::ST_OK;
            pred_in   = 1'b0;
            pct_in    = '0;
            state_in  = S_DONE;
            unique case (req_ff.func)
               kvt_pkg::FN_UPDATE: begin
                  if (arg_bad || req_ff.style_class >= 8'(CLASS_COUNT) ||
                      req_ff.sample_confidence == '0) begin
                     status_in = kvt_pkg::ST_ARG;
                  end else if (req_ff.consent_flag != 8'd1 ||
                               req_ff.local_flag != 8'd1) begin
                     status_in = kvt_pkg::ST_AUTH;
                     rej_in    = rej_ff + 32'd1;
                  end else if (!found_ff && used_ff == UW'(MAX_ENTRIES)) begin
                     status_in = kvt_pkg::ST_FULL;
                     rej_in    = rej_ff + 32'd1;
                  end else if (found_ff && tomb_vec[sel_ff]) begin
                     status_in = kvt_pkg::ST_REVOKED;
                     rej_in    = rej_ff + 32'd1;
                  end else begin
                     // a new entry burns one version number first
                     cmd.alloc      = !found_ff;
                     cmd.vote       = 1'b1;
                     cmd.set_active = 1'b1;
                     cmd.set_ver    = 1'b1;
                     cmd.version    = found_ff ? ver_ff + 32'd1 : ver_ff + 32'd2;
                     ver_in         = cmd.version;
                     used_in        = found_ff ? used_ff : used_ff + UW'(1);
                     acc_in         = acc_ff + 32'd1;
                  end
               end
               kvt_pkg::FN_FORGET: begin
                  if (arg_bad) begin
                     status_in = kvt_pkg::ST_ARG;
                  end else if (!found_ff && used_ff == UW'(MAX_ENTRIES)) begin
                     status_in = kvt_pkg::ST_FULL;
                  end else begin
                     cmd.alloc      = !found_ff;
                     cmd.clr_active = 1'b1;
                     cmd.set_tomb   = 1'b1;
                     cmd.set_ver    = 1'b1;
                     ver_in         = ver_ff + 32'd1;
                     used_in        = found_ff ? used_ff : used_ff + UW'(1);
                     rev_in         = rev_ff + 32'd1;
                  end
               end
               kvt_pkg::FN_PREDICT: begin
                  if (arg_bad) begin
                     status_in = kvt_pkg::ST_ARG;
                  end else if (!found_ff || !act_vec[sel_ff] || tomb_vec[sel_ff]) begin
                     status_in = kvt_pkg::ST_ABSTAIN;
                  end else begin
                     pred_in   = 1'b1;
                     pver_in   = ver_vec[sel_ff];
                     scan_in   = '0;
                     best_in   = '0;
                     second_in = '0;
                     total_in  = '0;
                     bi_in     = '0;
                     state_in  = S_SCAN;
                  end
               end
               kvt_pkg::FN_QUARANTINE: begin
                  cmd.quarantine = 1'b1;
                  epoch_in       = epoch_ff + 32'd1;
               end
               default: begin
               end
            endcase
         end
         S_SCAN: begin
            // one class per cycle off the head of the rotating ring
            cmd.shift = 1'b1;
            total_in  = total_ff + v;
            if (v > best_ff) begin
               second_in = best_ff;
               best_in   = v;
               bi_in     = 8'(scan_ff);
            end else if (v > second_ff) begin
               second_in = v;
            end
            scan_in = scan_ff + SW'(1);
            if (scan_ff == SW'(CLASS_COUNT - 1)) begin
               state_in = S_DIV;
               div_start = 1'b0;
            end
         end
         S_DIV: begin
            if (best_ff < min_votes_ff || margin < min_margin_ff) begin
               status_in = kvt_pkg::ST_ABSTAIN;
               state_in  = S_DONE;
            end else if (total_ff == '0) begin
               state_in = S_DONE;
            end else if (div_done) begin
               pct_in   = div_q[7:0];
               state_in = S_DONE;
            end else if (scan_ff != '0) begin
               div_start = 1'b1;
               scan_in   = '0;
            end
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         used_ff       <= '0;
         ver_ff        <= '0;
         acc_ff        <= '0;
         rej_ff        <= '0;
         rev_ff        <= '0;
         epoch_ff      <= 32'd1;
         rsp_valid_ff  <= 1'b0;
         min_votes_ff  <= 16'd3;
         min_margin_ff <= 8'd1;
         scan_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         ver_ff       <= ver_in;
         acc_ff       <= acc_in;
         rej_ff       <= rej_in;
         rev_ff       <= rev_in;
         epoch_ff     <= epoch_in;
         rsp_valid_ff <= rsp_valid_in;
         scan_ff      <= scan_in;
         if (csr_we) begin
            if (csr_index == kvt_pkg::CSR_MIN_MARGIN) begin
               min_margin_ff <= csr_wdata[7:0];
            end else begin
               min_votes_ff <= csr_wdata;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) begin
         req_ff <= req_data;
      end
      sel_ff    <= sel_in;
      found_ff  <= found_in;
      status_ff <= status_in;
      best_ff   <= best_in;
      second_ff <= second_in;
      total_ff  <= total_in;
      bi_ff     <= bi_in;
      pct_ff    <= pct_in;
      pver_ff   <= pver_in;
      pred_ff   <= pred_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // response beat
   always_comb begin
      rsp_data                = '0;
      rsp_data.status         = status_ff;
      if (pred_ff) begin
         rsp_data.best_class    = bi_ff;
         rsp_data.vote_sum      = total_ff;
         rsp_data.vote_lead     = margin;
         rsp_data.certainty     = pct_ff;
         rsp_data.entry_version = pver_ff;
      end
      rsp_data.active_count   = 5'(act_cnt);
      rsp_data.accepted_count = acc_ff;
      rsp_data.rejected_count = rej_ff;
      rsp_data.revoked_count  = rev_ff;
      rsp_data.epoch          = epoch_ff;
   end

   // checks
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= UW'(MAX_ENTRIES)) else $error("entry count past table size");
   a_one_hit: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_vec)) else $error("key held by two entries");
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while busy");
   a_start_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_valid) else $error("result too early");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for keyed_vote_table
// Drives update, forget, predict and quarantine commands with random gaps,
// predicts every response with a behavioral copy of the table and compares
// all response fields in order of issue.
// ----------------------------------------------------------------------------
module testbench;

   localparam int ENTRIES  = 16;
   localparam int CLASSES  = 4;
   localparam int MAX_GAP  = 18;
   localparam int DRAIN    = 60;
   localparam int REQ_W    = $bits(kvt_pkg::req_type);

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   kvt_pkg::req_type req_data = '0;
   logic    rsp_valid;
   kvt_pkg::rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic    csr_index = 1'b0;
   logic [15:0] csr_wdata = '0;

   keyed_vote_table #(.MAX_ENTRIES(ENTRIES), .CLASS_COUNT(CLASSES)) uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // shadow of the table
   logic [31:0] tbl_key [ENTRIES];
   logic [15:0] tbl_votes [ENTRIES][CLASSES];
   logic        tbl_active [ENTRIES];
   logic        tbl_tomb [ENTRIES];
   logic [31:0] tbl_ver [ENTRIES];
   int          used_cnt;
   logic [31:0] ver_ctr, acc_ctr, rej_ctr, rev_ctr, epoch_ctr;
   logic [15:0] thr_votes;
   logic [7:0]  thr_margin;

   kvt_pkg::rsp_type expected_rsps[$];
   int      mismatches = 0;
   int      beats_sent = 0;
   int      beats_checked = 0;
   int      predicts_given = 0;
   logic [31:0] key_pool[$];

   function automatic int find_key(logic [31:0] key);
      for (int i = 0; i < used_cnt; i++)
         if (tbl_key[i] == key) return i;
      return -1;
   endfunction

   function automatic int alloc_key(logic [31:0] key);
      int n;
      n = used_cnt;
      if (n >= ENTRIES) return -1;
      used_cnt = n + 1;
      tbl_key[n] = key;
      tbl_active[n] = 1'b0;
      tbl_tomb[n] = 1'b0;
      tbl_ver[n] = '0;
      for (int c = 0; c < CLASSES; c++) tbl_votes[n][c] = '0;
      return n;
   endfunction

   // compute the response of one command and advance the shadow state
   function automatic kvt_pkg::rsp_type table_step(kvt_pkg::req_type rq);
      kvt_pkg::rsp_type r;
      int e;
      logic [15:0] best, second, total, v;
      logic [7:0]  bi, margin;
      logic [31:0] pct;
      int live;
      r = '0;
      r.status = kvt_pkg::ST_OK;
      case (rq.func)
         kvt_pkg::FN_UPDATE: begin
            if (rq.feature_key == 0 || rq.style_class >= CLASSES ||
                rq.sample_confidence == 0) begin
               r.status = kvt_pkg::ST_ARG;
            end else if (rq.consent_flag != 8'd1 || rq.local_flag != 8'd1) begin
               rej_ctr++;
               r.status = kvt_pkg::ST_AUTH;
            end else begin
               e = find_key(rq.feature_key);
               if (e < 0) begin
                  e = alloc_key(rq.feature_key);
                  if (e >= 0) begin
                     tbl_active[e] = 1'b1;
                     ver_ctr++;
                     tbl_ver[e] = ver_ctr;
                  end
               end
               if (e < 0) begin
                  rej_ctr++;
                  r.status = kvt_pkg::ST_FULL;
               end else if (tbl_tomb[e]) begin
                  rej_ctr++;
                  r.status = kvt_pkg::ST_REVOKED;
               end else begin
                  if (tbl_votes[e][rq.style_class] != kvt_pkg::VOTE_MAX)
                     tbl_votes[e][rq.style_class]++;
                  tbl_active[e] = 1'b1;
                  ver_ctr++;
                  tbl_ver[e] = ver_ctr;
                  acc_ctr++;
               end
            end
         end
         kvt_pkg::FN_FORGET: begin
            if (rq.feature_key == 0) begin
               r.status = kvt_pkg::ST_ARG;
            end else begin
               e = find_key(rq.feature_key);
               if (e < 0) e = alloc_key(rq.feature_key);
               if (e < 0) begin
                  r.status = kvt_pkg::ST_FULL;
               end else begin
                  tbl_active[e] = 1'b0;
                  tbl_tomb[e] = 1'b1;
                  ver_ctr++;
                  tbl_ver[e] = ver_ctr;
                  rev_ctr++;
               end
            end
         end
         kvt_pkg::FN_PREDICT: begin
            e = (rq.feature_key == 0) ? -1 : find_key(rq.feature_key);
            if (rq.feature_key == 0) begin
               r.status = kvt_pkg::ST_ARG;
            end else if (e < 0 || !tbl_active[e] || tbl_tomb[e]) begin
               r.status = kvt_pkg::ST_ABSTAIN;
            end else begin
               best = 0; second = 0; bi = 0; total = 0;
               for (int c = 0; c < CLASSES; c++) begin
                  v = tbl_votes[e][c];
                  total = total + v;
                  if (v > best) begin
                     second = best;
                     best = v;
                     bi = c[7:0];
                  end else if (v > second) begin
                     second = v;
                  end
               end
               margin = 8'(best - second);
               r.best_class = bi;
               r.vote_sum = total;
               r.vote_lead = margin;
               r.entry_version = tbl_ver[e];
               if (best < thr_votes || margin < thr_margin) begin
                  r.status = kvt_pkg::ST_ABSTAIN;
               end else begin
                  // a wrapped total of zero gives no percentage
                  pct = (total == 0) ? 32'd0 : (32'(best) * 100) / 32'(total);
                  r.certainty = pct[7:0];
                  predicts_given++;
               end
            end
         end
         default: begin
            epoch_ctr++;
            for (int i = 0; i < used_cnt; i++) tbl_active[i] = 1'b0;
         end
      endcase
      live = 0;
      for (int i = 0; i < used_cnt; i++)
         if (tbl_active[i] && !tbl_tomb[i]) live++;
      r.active_count = live[4:0];
      r.accepted_count = acc_ctr;
      r.rejected_count = rej_ctr;
      r.revoked_count = rev_ctr;
      r.epoch = epoch_ctr;
      return r;
   endfunction

   // compare each response beat with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response beat: %p", rsp_data);
         end else begin
            kvt_pkg::rsp_type want;
            want = expected_rsps.pop_front();
            beats_checked++;
            if (rsp_data !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response %0d mismatch\n  expected %p\n  actual   %p",
                           beats_checked, want, rsp_data);
            end
         end
      end
   end

   // issue one command beat after a gap; the first falling edge is the one
   // after the previous beat's release of start
   task automatic send_cmd(kvt_pkg::req_type rq, int gap);
      repeat (gap + 1) @(negedge clock);
      req_data <= rq;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      expected_rsps.push_back(table_step(rq));
      beats_sent++;
      @(negedge clock);
      start <= 1'b0;
   endtask

   task automatic wait_drained();
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
   endtask

   task automatic write_reg(logic idx, logic [15:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == kvt_pkg::CSR_MIN_VOTES) thr_votes = val;
      else thr_margin = val[7:0];
   endtask

   function automatic kvt_pkg::req_type make_req(logic [1:0] fn, logic [31:0] key,
                                                 logic [7:0] cls, logic [7:0] conf,
                                                 logic [7:0] cf, logic [7:0] lf);
      kvt_pkg::req_type rq;
      rq.func = fn;
      rq.feature_key = key;
      rq.style_class = cls;
      rq.sample_confidence = conf;
      rq.consent_flag = cf;
      rq.local_flag = lf;
      return rq;
   endfunction

   function automatic logic [31:0] pick_key();
      if (key_pool.size() == 0 || $urandom_range(0, 9) == 0) return $urandom();
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
   endfunction

   function automatic kvt_pkg::req_type random_req();
      kvt_pkg::req_type rq;
      logic [REQ_W-1:0] raw;
      int sel;
      sel = $urandom_range(0, 99);
      rq = make_req(kvt_pkg::FN_UPDATE, pick_key(), 8'($urandom_range(0, CLASSES - 1)),
                    8'($urandom_range(1, 255)), 8'd1, 8'd1);
      if (sel < 50) begin
         // well-formed vote
      end else if (sel < 58) begin
         rq.func = kvt_pkg::FN_FORGET;
      end else if (sel < 85) begin
         rq.func = kvt_pkg::FN_PREDICT;
      end else if (sel < 88) begin
         rq.func = kvt_pkg::FN_QUARANTINE;
      end else if (sel < 96) begin
         // broken vote: raw fields
         rq = make_req(kvt_pkg::FN_UPDATE,
                       ($urandom_range(0, 3) == 0) ? 32'd0 : pick_key(),
                       8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()));
         if ($urandom_range(0, 1)) rq.consent_flag = 8'd1;
      end else begin
         raw = REQ_W'({$urandom(), $urandom(), $urandom()});
         rq = kvt_pkg::req_type'(raw);
      end
      return rq;
   endfunction

   // directed: extremes, every function and the special cases
   task automatic test_directed();
      key_pool = '{32'hFFFF_FFFF, 32'h0000_0001, 32'hA5A5_5A5A};
      send_cmd(make_req(kvt_pkg::FN_PREDICT, 32'h1, 0, 0, 0, 0), 0);      // missing key
      send_cmd(make_req(kvt_pkg::FN_UPDATE, 32'h0, 0, 1, 1, 1), 0);       // zero key
      send_cmd(make_req(kvt_pkg::FN_UPDATE, 32'h1, 8'(CLASSES), 1, 1, 1), 1); // bad class
      send_cmd(make_req(kvt_pkg::FN_UPDATE, 32'h1, 0, 0, 1, 1), 0);       // zero confidence
      send_cmd(make_req(kvt_pkg::FN_UPDATE, 32'h1, 0, 255, 2, 1), 3);     // no consent
      send_cmd(make_req(kvt_pkg::FN_UPDATE, 32'h1, 0, 255, 1, 255), 0);   // not local
      send_cmd(make_req(kvt_pkg::FN_UPDATE, 32'hFFFF_FFFF, 3, 8'hFF, 1, 1), 0);
      send_cmd(make_req(kvt_pkg::FN_UPDATE, 32'hFFFF_FFFF, 3, 8'h80, 1, 1), 2);
      send_cmd(make_req(kvt_pkg::FN_UPDATE, 32'hFFFF_FFFF, 3, 8'h01, 1, 1), 0);
      send_cmd(make_req(kvt_pkg::FN_PREDICT, 32'hFFFF_FFFF, 0, 0, 0, 0), 0); // predicts
      send_cmd(make_req(kvt_pkg::FN_UPDATE, 32'h1, 1, 1, 1, 1), 0);
      send_cmd(make_req(kvt_pkg::FN_PREDICT, 32'h1, 0, 0, 0, 0), 5);      // below threshold
      send_cmd(make_req(kvt_pkg::FN_PREDICT, 32'h0, 0, 0, 0, 0), 0);      // zero key
      send_cmd(make_req(kvt_pkg::FN_FORGET, 32'h1, 0, 0, 0, 0), 0);
      send_cmd(make_req(kvt_pkg::FN_UPDATE, 32'h1, 1, 1, 1, 1), 0);       // revoked
      send_cmd(make_req(kvt_pkg::FN_PREDICT, 32'h1, 0, 0, 0, 0), 0);      // tombstoned
      send_cmd(make_req(kvt_pkg::FN_FORGET, 32'hA5A5_5A5A, 0, 0, 0, 0), 0); // forget new key
      send_cmd(make_req(kvt_pkg::FN_FORGET, 32'h0, 0, 0, 0, 0), 0);
      send_cmd(make_req(kvt_pkg::FN_QUARANTINE, 32'h0, 0, 0, 0, 0), 0);
      send_cmd(make_req(kvt_pkg::FN_PREDICT, 32'hFFFF_FFFF, 0, 0, 0, 0), 0); // inactive
      send_cmd(make_req(kvt_pkg::FN_UPDATE, 32'hFFFF_FFFF, 2, 1, 1, 1), 0);  // reactivate
      send_cmd(make_req(kvt_pkg::FN_PREDICT, 32'hFFFF_FFFF, 0, 0, 0, 0), 0);
      wait_drained();
   endtask

   // thresholds at their extremes
   task automatic test_thresholds();
      write_reg(kvt_pkg::CSR_MIN_VOTES, 16'd0);
      write_reg(kvt_pkg::CSR_MIN_MARGIN, 16'd0);
      send_cmd(make_req(kvt_pkg::FN_PREDICT, 32'hFFFF_FFFF, 0, 0, 0, 0), 0);
      wait_drained();
      write_reg(kvt_pkg::CSR_MIN_VOTES, 16'hFFFF);
      write_reg(kvt_pkg::CSR_MIN_MARGIN, 16'h00FF);
      send_cmd(make_req(kvt_pkg::FN_PREDICT, 32'hFFFF_FFFF, 0, 0, 0, 0), 0);
      wait_drained();
   endtask

   // random traffic under one threshold setting
   task automatic test_random(int count, logic [15:0] votes, logic [7:0] margin);
      kvt_pkg::req_type rq;
      int gap;
      write_reg(kvt_pkg::CSR_MIN_VOTES, votes);
      write_reg(kvt_pkg::CSR_MIN_MARGIN, {8'd0, margin});
      for (int n = 0; n < count; n++) begin
         rq = random_req();
         if (rq.feature_key != 0 && key_pool.size() < 24) key_pool.push_back(rq.feature_key);
         // runs without idling, otherwise a random gap
         gap = ((n / 40) % 3 == 0) ? 0 : $urandom_range(0, MAX_GAP);
         send_cmd(rq, gap);
         if (n == count / 2) wait_drained();
      end
      wait_drained();
   endtask

   // fill the table, then hit full on update and forget
   task automatic test_full();
      for (int i = 0; i < ENTRIES + 2; i++) begin
         send_cmd(make_req(kvt_pkg::FN_UPDATE, $urandom() | 32'h1, 0, 1, 1, 1),
                  $urandom_range(0, 2));
         send_cmd(make_req(kvt_pkg::FN_FORGET, $urandom() | 32'h1, 0, 0, 0, 0), 0);
      end
      wait_drained();
   endtask

   initial begin
      thr_votes = 16'd3;
      thr_margin = 8'd1;
      used_cnt = 0;
      ver_ctr = 0; acc_ctr = 0; rej_ctr = 0; rev_ctr = 0; epoch_ctr = 1;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_thresholds();
      test_random(300, 16'd3, 8'd1);
      test_random(200, 16'd1, 8'd0);
      test_random(180, 16'd2, 8'd2);
      test_full();
      test_random(40, 16'd0, 8'd0);
      $display("covered %0d command beats, %0d responses checked, %0d confident predicts",
               beats_sent, beats_checked, predicts_given);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("%0d mismatches, %0d responses missing", mismatches, expected_rsps.size());
         $display("testbench: errors");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout");
      $display("testbench: errors");
      $finish;
   end

endmodule
